>>> hdl/json_string_unescape_utf8_defines.svh
// Assertion macros for the JSON string unescaper.
`ifndef JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH

`ifndef SYNTHESIS
`define JSU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define JSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define JSU_ASSERT(lbl, prop, msg)
`define JSU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> hdl/jsu_pkg.sv
package jsu_pkg;

  localparam int QDEPTH = 4;

  typedef enum logic [2:0] {
    M_IDLE,
    M_BODY,
    M_ESC,
    M_HEX1,
    M_WANTBS,
    M_WANTU,
    M_HEX2,
    M_HALT
  } mode_t;

  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_ERR   = 2'd2;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_NO_QUOTE = 3'd1;
  localparam logic [2:0] ERR_CONTROL  = 3'd2;
  localparam logic [2:0] ERR_ESCAPE   = 3'd3;
  localparam logic [2:0] ERR_HEX      = 3'd4;
  localparam logic [2:0] ERR_ZERO     = 3'd5;
  localparam logic [2:0] ERR_SURR     = 3'd6;
  localparam logic [2:0] ERR_TEXT_END = 3'd7;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_BS_OUT = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0C;

  localparam logic [5:0] SURR_HIGH = 6'b110110;
  localparam logic [5:0] SURR_LOW  = 6'b110111;
  localparam logic [10:0] SUPP_BASE = 11'h040;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic [1:0]      kind;
    logic [2:0]      err;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic desc_t mk_byte(input logic [7:0] b);
    desc_t d;
    d = '0;
    d.bytes[0] = b;
    d.kind = KIND_BYTE;
    return d;
  endfunction

  function automatic desc_t mk_close();
    desc_t d;
    d = '0;
    d.kind = KIND_CLOSE;
    return d;
  endfunction

  function automatic desc_t mk_err(input logic [2:0] e);
    desc_t d;
    d = '0;
    d.kind = KIND_ERR;
    d.err = e;
    return d;
  endfunction

  function automatic logic [4:0] hex_nib(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  function automatic desc_t utf8_enc(input logic [20:0] cp);
    desc_t d;
    d = '0;
    d.kind = KIND_BYTE;
    if (cp <= 21'h7F) begin
      d.bytes[0] = cp[7:0];
      d.last_idx = 2'd0;
    end else if (cp <= 21'h7FF) begin
      d.bytes[0] = {3'b110, cp[10:6]};
      d.bytes[1] = {2'b10, cp[5:0]};
      d.last_idx = 2'd1;
    end else if (cp <= 21'hFFFF) begin
      d.bytes[0] = {4'b1110, cp[15:12]};
      d.bytes[1] = {2'b10, cp[11:6]};
      d.bytes[2] = {2'b10, cp[5:0]};
      d.last_idx = 2'd2;
    end else begin
      d.bytes[0] = {5'b11110, cp[20:18]};
      d.bytes[1] = {2'b10, cp[17:12]};
      d.bytes[2] = {2'b10, cp[11:6]};
      d.bytes[3] = {2'b10, cp[5:0]};
      d.last_idx = 2'd3;
    end
    return d;
  endfunction

endpackage

>>> hdl/jsu_front.sv
module jsu_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte,
  input  logic             text_end,
  input  jsu_pkg::q_stat_t q_stat,
  output logic             push,
  output jsu_pkg::desc_t   push_desc
);
  import jsu_pkg::*;

  mode_t       mode, mode_next;
  logic [15:0] hex_value, hex_value_next;
  logic [1:0]  hex_seen, hex_seen_next;
  logic [9:0]  high_bits, high_bits_next;
  logic        accept;
  logic        emit;
  logic [4:0]  nib;
  logic [15:0] hv;
  logic [20:0] pair_cp;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && emit;
  assign nib      = hex_nib(in_byte);
  assign hv       = {hex_value[11:0], nib[3:0]};
  assign pair_cp  = {({1'b0, high_bits} + SUPP_BASE), hv[9:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= M_IDLE;
      hex_value <= '0;
      hex_seen  <= '0;
      high_bits <= '0;
    end else if (accept) begin
      mode      <= mode_next;
      hex_value <= hex_value_next;
      hex_seen  <= hex_seen_next;
      high_bits <= high_bits_next;
    end
  end

  always_comb begin
    mode_next      = mode;
    hex_value_next = hex_value;
    hex_seen_next  = hex_seen;
    high_bits_next = high_bits;
    emit           = 1'b0;
    push_desc      = mk_close();
    if (text_end) begin
      mode_next      = M_IDLE;
      hex_value_next = '0;
      hex_seen_next  = '0;
      high_bits_next = '0;
      if (mode != M_IDLE && mode != M_HALT) begin
        emit      = 1'b1;
        push_desc = mk_err(ERR_TEXT_END);
      end
    end else begin
      unique case (mode)
        M_IDLE: begin
          if (in_byte == CH_QUOTE) begin
            mode_next = M_BODY;
          end else if (in_byte != CH_SPACE && in_byte != CH_TAB &&
                       in_byte != CH_CR && in_byte != CH_LF) begin
            mode_next = M_HALT;
            emit      = 1'b1;
            push_desc = mk_err(ERR_NO_QUOTE);
          end
        end
        M_BODY: begin
          emit = 1'b1;
          if (in_byte == CH_QUOTE) begin
            mode_next = M_IDLE;
            push_desc = mk_close();
          end else if (in_byte < CH_SPACE) begin
            mode_next = M_HALT;
            push_desc = mk_err(ERR_CONTROL);
          end else if (in_byte == CH_BSLASH) begin
            mode_next = M_ESC;
            emit      = 1'b0;
          end else begin
            push_desc = mk_byte(in_byte);
          end
        end
        M_ESC: begin
          mode_next = M_BODY;
          emit      = 1'b1;
          unique case (in_byte)
            CH_QUOTE:  push_desc = mk_byte(CH_QUOTE);
            CH_BSLASH: push_desc = mk_byte(CH_BSLASH);
            CH_SLASH:  push_desc = mk_byte(CH_SLASH);
            CH_B:      push_desc = mk_byte(CH_BS_OUT);
            CH_F:      push_desc = mk_byte(CH_FF);
            CH_N:      push_desc = mk_byte(CH_LF);
            CH_R:      push_desc = mk_byte(CH_CR);
            CH_T:      push_desc = mk_byte(CH_TAB);
            CH_U: begin
              mode_next      = M_HEX1;
              hex_value_next = '0;
              hex_seen_next  = '0;
              emit           = 1'b0;
            end
            default: begin
              mode_next = M_HALT;
              push_desc = mk_err(ERR_ESCAPE);
            end
          endcase
        end
        M_HEX1, M_HEX2: begin
          if (!nib[4]) begin
            mode_next = M_HALT;
            emit      = 1'b1;
            push_desc = mk_err(ERR_HEX);
          end else begin
            hex_value_next = hv;
            hex_seen_next  = hex_seen + 2'd1;
            if (hex_seen == 2'd3) begin
              emit = 1'b1;
              if (mode == M_HEX2) begin
                if (hv[15:10] != SURR_LOW) begin
                  mode_next = M_HALT;
                  push_desc = mk_err(ERR_SURR);
                end else begin
                  mode_next = M_BODY;
                  push_desc = utf8_enc(pair_cp);
                end
              end else if (hv == '0) begin
                mode_next = M_HALT;
                push_desc = mk_err(ERR_ZERO);
              end else if (hv[15:10] == SURR_HIGH) begin
                high_bits_next = hv[9:0];
                mode_next      = M_WANTBS;
                emit           = 1'b0;
              end else if (hv[15:10] == SURR_LOW) begin
                mode_next = M_HALT;
                push_desc = mk_err(ERR_SURR);
              end else begin
                mode_next = M_BODY;
                push_desc = utf8_enc({5'd0, hv});
              end
            end
          end
        end
        M_WANTBS: begin
          if (in_byte == CH_BSLASH) begin
            mode_next = M_WANTU;
          end else begin
            mode_next = M_HALT;
            emit      = 1'b1;
            push_desc = mk_err(ERR_SURR);
          end
        end
        M_WANTU: begin
          if (in_byte == CH_U) begin
            mode_next      = M_HEX2;
            hex_value_next = '0;
            hex_seen_next  = '0;
          end else begin
            mode_next = M_HALT;
            emit      = 1'b1;
            push_desc = mk_err(ERR_SURR);
          end
        end
        M_HALT: begin
          mode_next = M_HALT;
        end
      endcase
    end
  end

endmodule

>>> hdl/jsu_queue.sv
module jsu_queue #(
  parameter int DEPTH = jsu_pkg::QDEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  jsu_pkg::desc_t    push_desc,
  input  logic              pop,
  output jsu_pkg::desc_t    head,
  output jsu_pkg::q_stat_t  q_stat
);
  import jsu_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  desc_t         slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign q_stat.full  = (count == CW'(DEPTH));
  assign q_stat.empty = (count == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

>>> hdl/jsu_back.sv
module jsu_back (
  input  logic             clk,
  input  logic             rst,
  input  jsu_pkg::desc_t   head,
  input  jsu_pkg::q_stat_t q_stat,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic [1:0]       out_kind,
  output logic [2:0]       error_kind,
  output logic             last_of_run
);
  import jsu_pkg::*;

  logic [1:0] pos;
  logic       load;
  logic       take;
  logic       at_last;

  assign load    = !out_valid || out_ready;
  assign take    = load && !q_stat.empty;
  assign at_last = (pos == head.last_idx);
  assign pop     = take && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= '0;
    end else if (load) begin
      out_valid <= !q_stat.empty;
      if (take) begin
        pos <= at_last ? 2'd0 : pos + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_byte    <= head.bytes[pos];
      out_kind    <= head.kind;
      error_kind  <= head.err;
      last_of_run <= at_last;
    end
  end

endmodule

>>> hdl/json_string_unescape_utf8.sv
// JSON string unescaper: raw text bytes in, decoded UTF-8 bytes out.
// Input channel: in_valid/in_ready with in_byte and text_end, one request
// per text byte. Output channel: out_valid/out_ready with out_byte,
// out_kind (byte, string closed, error), error_kind and last_of_run, which
// marks the final result caused by one input byte.
// A byte is decoded in the cycle it is accepted and its results enter a
// DEPTH-entry queue; the earliest result passes from the queue into the
// output register before it is presented. One input byte is taken per
// cycle while the queue has room, and one result leaves per cycle while
// the receiver is ready; a \u escape that yields 3 or 4 UTF-8 bytes
// presents them one after another, the queue absorbing the burst.
// Whitespace, opening quotes, backslashes and partial hex give no result.
// After an error the decoder ignores bytes until text_end.
// Reset clears the decoder to idle (awaiting an opening quote) and empties
// the queue and output register. When the receiver stalls, the output
// register holds, the queue fills, and in_ready drops once it is full.
`include "json_string_unescape_utf8_defines.svh"
module json_string_unescape_utf8 #(
  parameter int DEPTH = jsu_pkg::QDEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       text_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] out_kind,
  output logic [2:0] error_kind,
  output logic       last_of_run
);
  import jsu_pkg::*;

  q_stat_t q_stat;
  desc_t   push_desc;
  desc_t   head;
  logic    q_push;
  logic    q_pop;

  jsu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .text_end  (text_end),
    .q_stat    (q_stat),
    .push      (q_push),
    .push_desc (push_desc)
  );

  jsu_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_desc (push_desc),
    .pop       (q_pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  jsu_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_stat      (q_stat),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .out_kind    (out_kind),
    .error_kind  (error_kind),
    .last_of_run (last_of_run)
  );

  `JSU_ASSERT(a_term_last, out_valid && out_kind != KIND_BYTE |-> last_of_run, "end not last")
  `JSU_ASSERT(a_err, out_valid |-> (out_kind == KIND_ERR) == (error_kind != ERR_NONE), "bad error")
  `JSU_ASSERT(a_kind_range, out_valid |-> out_kind != 2'd3, "undefined result kind")
  `JSU_ASSERT_NEXT(a_push_fill, q_push && !q_stat.full, !q_stat.empty, "queue empty after request")

endmodule

>>> sim/json_string_unescape_utf8_tb.sv
module json_string_unescape_utf8_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jsu_pkg::*;

  localparam logic [7:0] DIG_0 = 8'h30;
  localparam logic [7:0] DIG_9 = 8'h39;
  localparam logic [7:0] LOW_A = 8'h61;
  localparam logic [7:0] LOW_F = 8'h66;
  localparam logic [7:0] UP_A  = 8'h41;
  localparam logic [7:0] UP_F  = 8'h46;

  localparam logic [0:7][7:0] ESC_LETTERS = {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B,
                                             CH_F, CH_N, CH_R, CH_T};
  localparam logic [0:3][7:0] WS_BYTES = {CH_SPACE, CH_TAB, CH_CR, CH_LF};
  localparam logic [0:7][15:0] BMP_EDGES = {16'h0001, 16'h007F, 16'h0080, 16'h07FF,
                                            16'h0800, 16'hD7FF, 16'hE000, 16'hFFFF};

  typedef enum int {
    F_NONE, F_NOISE, F_CONTROL, F_ESCAPE, F_HEX, F_ZERO, F_LONE_LOW, F_NO_BS, F_NO_U,
    F_BAD_LOW, F_END_BODY, F_END_ESC, F_END_HEX, F_END_WANTBS, F_END_WANTU, F_END_HEX2
  } fault_t;

  typedef struct {
    logic [7:0] data;
    logic       te;
  } text_req_t;

  typedef struct {
    logic [7:0] data;
    logic [1:0] kind;
    logic [2:0] err;
    logic       last;
  } result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       text_end = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic [2:0] error_kind;
  logic       last_of_run;

  text_req_t pending_text[$];
  result_t   decoded_due[$];
  result_t   run_results[$];

  mode_t       dec_mode = M_IDLE;
  logic [15:0] hex_acc = '0;
  logic [1:0]  hex_cnt = '0;
  logic [9:0]  hi_bits = '0;

  bit        in_fire = 1'b0;
  bit        rx_hold = 1'b0;
  bit        hold_arm = 1'b0;
  int        tx_idle_pct = 0;
  int        rx_idle_pct = 0;
  int        n_pushed = 0;
  int        bad_results = 0;
  text_req_t cur_req;

  json_string_unescape_utf8 u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .text_end   (text_end),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .out_kind   (out_kind),
    .error_kind (error_kind),
    .last_of_run(last_of_run)
  );

  always #4 clk = ~clk;

  function automatic int nibble_of(input logic [7:0] c);
    if (c >= DIG_0 && c <= DIG_9) return int'(c) - int'(DIG_0);
    if (c >= LOW_A && c <= LOW_F) return int'(c) - int'(LOW_A) + 10;
    if (c >= UP_A && c <= UP_F) return int'(c) - int'(UP_A) + 10;
    return -1;
  endfunction

  function automatic bit is_space(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
  endfunction

  function automatic bit is_escape_letter(input logic [7:0] c);
    for (int i = 0; i < 8; i++) begin
      if (c == ESC_LETTERS[i]) return 1'b1;
    end
    return c == CH_U;
  endfunction

  // ---------------------------------------------------------------- decoder
  task automatic add_result(input logic [7:0] b, input logic [1:0] k, input logic [2:0] e);
    result_t r;
    r.data = b;
    r.kind = k;
    r.err  = e;
    r.last = 1'b0;
    run_results = {run_results, r};
  endtask

  task automatic add_byte(input logic [7:0] b);
    add_result(b, KIND_BYTE, ERR_NONE);
  endtask

  task automatic halt_with(input logic [2:0] e);
    add_result(8'h00, KIND_ERR, e);
    dec_mode = M_HALT;
  endtask

  task automatic add_code_point(input logic [20:0] cp);
    if (cp <= 21'h7F) begin
      add_byte(cp[7:0]);
    end else if (cp <= 21'h7FF) begin
      add_byte(8'hC0 | 8'(cp >> 6));
      add_byte(8'h80 | 8'(cp & 21'h3F));
    end else if (cp <= 21'hFFFF) begin
      add_byte(8'hE0 | 8'(cp >> 12));
      add_byte(8'h80 | 8'((cp >> 6) & 21'h3F));
      add_byte(8'h80 | 8'(cp & 21'h3F));
    end else begin
      add_byte(8'hF0 | 8'((cp >> 18) & 21'h07));
      add_byte(8'h80 | 8'((cp >> 12) & 21'h3F));
      add_byte(8'h80 | 8'((cp >> 6) & 21'h3F));
      add_byte(8'h80 | 8'(cp & 21'h3F));
    end
  endtask

  task automatic unescape_byte(input logic [7:0] c, input logic te);
    int h;
    run_results.delete();
    if (te) begin
      if (dec_mode != M_IDLE && dec_mode != M_HALT) add_result(8'h00, KIND_ERR, ERR_TEXT_END);
      dec_mode = M_IDLE;
      hex_acc = '0;
      hex_cnt = '0;
      hi_bits = '0;
    end else begin
      case (dec_mode)
        M_IDLE: begin
          if (c == CH_QUOTE) dec_mode = M_BODY;
          else if (!is_space(c)) halt_with(ERR_NO_QUOTE);
        end
        M_BODY: begin
          if (c == CH_QUOTE) begin
            dec_mode = M_IDLE;
            add_result(8'h00, KIND_CLOSE, ERR_NONE);
          end else if (c < CH_SPACE) begin
            halt_with(ERR_CONTROL);
          end else if (c == CH_BSLASH) begin
            dec_mode = M_ESC;
          end else begin
            add_byte(c);
          end
        end
        M_ESC: begin
          dec_mode = M_BODY;
          case (c)
            CH_QUOTE:  add_byte(CH_QUOTE);
            CH_BSLASH: add_byte(CH_BSLASH);
            CH_SLASH:  add_byte(CH_SLASH);
            CH_B:      add_byte(CH_BS_OUT);
            CH_F:      add_byte(CH_FF);
            CH_N:      add_byte(CH_LF);
            CH_R:      add_byte(CH_CR);
            CH_T:      add_byte(CH_TAB);
            CH_U: begin
              dec_mode = M_HEX1;
              hex_acc = '0;
              hex_cnt = '0;
            end
            default:   halt_with(ERR_ESCAPE);
          endcase
        end
        M_HEX1, M_HEX2: begin
          h = nibble_of(c);
          if (h < 0) begin
            halt_with(ERR_HEX);
          end else begin
            hex_acc = {hex_acc[11:0], 4'(h)};
            if (hex_cnt != 2'd3) begin
              hex_cnt = hex_cnt + 2'd1;
            end else begin
              hex_cnt = '0;
              if (dec_mode == M_HEX2) begin
                if (hex_acc < 16'hDC00 || hex_acc > 16'hDFFF) begin
                  halt_with(ERR_SURR);
                end else begin
                  dec_mode = M_BODY;
                  add_code_point(21'h10000 + 21'({hi_bits, hex_acc[9:0]}));
                end
              end else if (hex_acc == 16'h0000) begin
                halt_with(ERR_ZERO);
              end else if (hex_acc >= 16'hD800 && hex_acc <= 16'hDBFF) begin
                hi_bits = hex_acc[9:0];
                dec_mode = M_WANTBS;
              end else if (hex_acc >= 16'hDC00 && hex_acc <= 16'hDFFF) begin
                halt_with(ERR_SURR);
              end else begin
                dec_mode = M_BODY;
                add_code_point(21'(hex_acc));
              end
            end
          end
        end
        M_WANTBS: begin
          if (c != CH_BSLASH) halt_with(ERR_SURR);
          else dec_mode = M_WANTU;
        end
        M_WANTU: begin
          if (c != CH_U) begin
            halt_with(ERR_SURR);
          end else begin
            dec_mode = M_HEX2;
            hex_acc = '0;
            hex_cnt = '0;
          end
        end
        default: ;
      endcase
    end
    if (run_results.size() > 0) run_results[run_results.size() - 1].last = 1'b1;
    foreach (run_results[i]) decoded_due = {decoded_due, run_results[i]};
  endtask

  // ---------------------------------------------------------------- text generation
  task automatic push(input logic [7:0] b, input logic te = 1'b0);
    text_req_t r;
    r.data = b;
    r.te   = te;
    pending_text = {pending_text, r};
    n_pushed++;
  endtask

  task automatic push_end();
    push(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic push_hex_digits(input logic [15:0] v, input int count);
    logic [3:0] nib;
    for (int i = 3; i > 3 - count; i--) begin
      nib = v[i*4 +: 4];
      if (nib < 4'd10) push(DIG_0 + 8'(nib));
      else if ($urandom_range(1) != 0) push(UP_A + 8'(nib) - 8'd10);
      else push(LOW_A + 8'(nib) - 8'd10);
    end
  endtask

  task automatic push_uesc(input logic [15:0] v);
    push(CH_BSLASH);
    push(CH_U);
    push_hex_digits(v, 4);
  endtask

  function automatic logic [15:0] rand_bmp();
    case ($urandom_range(4))
      0:       return 16'($urandom_range(16'h7F, 16'h01));
      1:       return 16'($urandom_range(16'h7FF, 16'h80));
      2:       return 16'($urandom_range(16'hD7FF, 16'h800));
      3:       return 16'($urandom_range(16'hFFFF, 16'hE000));
      default: return BMP_EDGES[$urandom_range(7)];
    endcase
  endfunction

  function automatic logic [15:0] rand_high();
    return 16'hD800 | 16'($urandom_range(1023));
  endfunction

  function automatic logic [15:0] rand_low();
    return 16'hDC00 | 16'($urandom_range(1023));
  endfunction

  function automatic logic [7:0] rand_plain();
    logic [7:0] b;
    do b = 8'($urandom_range(255, 8'h20)); while (b == CH_QUOTE || b == CH_BSLASH);
    return b;
  endfunction

  task automatic gen_string();
    fault_t     fault;
    logic [7:0] b;
    logic [15:0] v;
    repeat ($urandom_range(2)) push(WS_BYTES[$urandom_range(3)]);
    fault = F_NONE;
    if ($urandom_range(99) < 30) fault = fault_t'($urandom_range(F_END_HEX2, F_NOISE));
    if (fault == F_NOISE) begin
      do b = 8'($urandom_range(255)); while (is_space(b) || b == CH_QUOTE);
      push(b);
    end else begin
      push(CH_QUOTE);
      repeat ($urandom_range(8, 1)) begin
        case ($urandom_range(9))
          5, 6: begin
            push(CH_BSLASH);
            push(ESC_LETTERS[$urandom_range(7)]);
          end
          7, 8: push_uesc(rand_bmp());
          9: begin
            push_uesc(rand_high());
            push_uesc(rand_low());
          end
          default: push(rand_plain());
        endcase
      end
      case (fault)
        F_CONTROL: push(8'($urandom_range(8'h1F)));
        F_ESCAPE: begin
          push(CH_BSLASH);
          do b = 8'($urandom_range(255)); while (is_escape_letter(b));
          push(b);
        end
        F_HEX, F_END_HEX: begin
          push(CH_BSLASH);
          push(CH_U);
          push_hex_digits(16'($urandom_range(16'hFFFF)), $urandom_range(3));
          if (fault == F_HEX) begin
            do b = 8'($urandom_range(255)); while (nibble_of(b) >= 0);
            push(b);
          end
        end
        F_ZERO: push_uesc(16'h0000);
        F_LONE_LOW: push_uesc(rand_low());
        F_NO_BS: begin
          push_uesc(rand_high());
          do b = 8'($urandom_range(255)); while (b == CH_BSLASH);
          push(b);
        end
        F_NO_U: begin
          push_uesc(rand_high());
          push(CH_BSLASH);
          do b = 8'($urandom_range(255)); while (b == CH_U);
          push(b);
        end
        F_BAD_LOW: begin
          push_uesc(rand_high());
          case ($urandom_range(2))
            0:       v = 16'h0000;
            1:       v = 16'($urandom_range(16'hDBFF));
            default: v = 16'($urandom_range(16'hFFFF, 16'hE000));
          endcase
          push_uesc(v);
        end
        F_END_ESC: push(CH_BSLASH);
        F_END_WANTBS: push_uesc(rand_high());
        F_END_WANTU: begin
          push_uesc(rand_high());
          push(CH_BSLASH);
        end
        F_END_HEX2: begin
          push_uesc(rand_high());
          push(CH_BSLASH);
          push(CH_U);
          push_hex_digits(rand_low(), $urandom_range(3));
        end
        default: ;
      endcase
    end
    if (fault == F_NONE) begin
      push(CH_QUOTE);
      if ($urandom_range(3) == 0) push_end();
    end else if (fault >= F_END_BODY) begin
      push_end();
    end else begin
      // bytes after an error are swallowed until the text ends
      repeat ($urandom_range(2)) push(8'($urandom_range(255)));
      push_end();
    end
  endtask

  task automatic gen_text(input int count);
    int goal;
    goal = n_pushed + count;
    while (n_pushed < goal) gen_string();
  endtask

  task automatic drain();
    while (pending_text.size() != 0 || in_valid) @(posedge clk);
    while (decoded_due.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- driver and receiver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pending_text.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        cur_req = pending_text.pop_front();
        in_valid <= 1'b1;
        in_byte  <= cur_req.data;
        text_end <= cur_req.te;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin : monitor
    result_t want;
    in_fire = !rst && in_valid && in_ready;
    if (in_fire) unescape_byte(in_byte, text_end);
    if (!rst && out_valid && out_ready) begin
      if (decoded_due.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("unexpected result: data=%02h kind=%0d err=%0d last=%0b",
                   out_byte, out_kind, error_kind, last_of_run);
      end else begin
        want = decoded_due.pop_front();
        if (out_byte !== want.data || out_kind !== want.kind ||
            error_kind !== want.err || last_of_run !== want.last) begin
          bad_results++;
          if (bad_results <= 10)
            $display("mismatch: want %02h/%0d/%0d/%0b got %02h/%0d/%0d/%0b",
                     want.data, want.kind, want.err, want.last,
                     out_byte, out_kind, error_kind, last_of_run);
        end
      end
    end
  end

  // hold the output side long enough for the queue to fill and in_ready to drop
  initial begin
    wait (hold_arm);
    rx_hold = 1'b1;
    repeat (120) @(posedge clk);
    rx_hold = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    tx_idle_pct = 6;
    rx_idle_pct = 77;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    push(CH_SPACE);
    push(CH_QUOTE);
    push(8'hFF);
    push(CH_SPACE);
    push_uesc(16'h0000);
    push(8'h41);
    push_end();
    push(CH_QUOTE);
    push_uesc(16'hDBFF);
    push_uesc(16'hDFFF);
    push(CH_QUOTE);
    push(8'h00);
    push_end();
    push(CH_QUOTE);
    push_end();
    gen_text(90);
    drain();

    tx_idle_pct = 77;
    rx_idle_pct = 6;
    gen_text(120);
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    gen_text(130);
    hold_arm = 1'b1;
    drain();

    repeat (30) @(posedge clk);
    if (bad_results == 0 && decoded_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/jsu_pkg.sv
hdl/jsu_front.sv
hdl/jsu_queue.sv
hdl/jsu_back.sv
hdl/json_string_unescape_utf8.sv
sim/json_string_unescape_utf8_tb.sv
